// ===== sv/bmss_pkg.sv =====
`default_nettype none
package bmss_pkg;
  localparam int DEF_MAX_SYMBOLS = 26;
  localparam int DEF_WORD_LIMIT  = 25;
  localparam int DEF_COUNT_WIDTH = 16;
  localparam int SYM_W = 5;
  localparam int RND_W = 32;
  localparam int ALPHA_LIMIT = 26;
endpackage
`default_nettype wire

// ===== sv/bmss_mem.sv =====
`default_nettype none
module bmss_mem #(
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/bmss_mod.sv =====
`default_nettype none
module bmss_mod #(
  parameter int CW = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [bmss_pkg::RND_W-1:0] dividend,
  input  wire logic [CW-1:0]             divisor,
  output logic                           done,
  output logic      [CW-1:0]             rem
);
  import bmss_pkg::*;
  localparam int NW = $clog2(RND_W + 1);

  logic [RND_W-1:0] q_r;
  logic [CW-1:0]    d_r;
  logic [CW-1:0]    rem_r;
  logic [NW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [CW:0]      trial;

  assign trial = {rem_r, q_r[RND_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        q_r   <= dividend;
        d_r   <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
      end else if (run_r) begin
        q_r <= {q_r[RND_W-2:0], 1'b0};
        if (trial >= {1'b0, d_r}) begin
          rem_r <= CW'(trial - {1'b0, d_r});
        end else begin
          rem_r <= trial[CW-1:0];
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == NW'(RND_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ===== sv/bigram_markov_symbol_sampler.sv =====
`default_nettype none
// bigram symbol sampler: trains first-order counts and draws word symbols
// input: an item is taken when start is high and busy is low; in_func 0
//   trains on in_symbol with its flags, in_func 1 draws the next symbol
// output: one result per draw, shown for one cycle with out_valid high;
//   the receiver cannot stall, so results are never held back
// config: cfg_num_symbols is written when cfg_valid and cfg_ready are high,
//   cfg_ready is always high; write only while busy is low
// timing: all counts live in one memory with a registered read, one read
//   and one write a cycle. a train item does up to two count bumps, each
//   as read total, check and write total, write cell, next. a draw at the
//   length limit leaves busy low and shows its result the next cycle; an
//   empty row keeps busy high through the total read and check; otherwise
//   busy stays high for the bit-serial remainder and then a read and a
//   compare per scanned column, up to 27 columns; the result shows in the
//   cycle in which busy falls
// reset: after rst_n the memory is swept to zero, one entry a cycle, all
//   2**(clog2(MAX_SYMBOLS+1)+clog2(MAX_SYMBOLS+2)) entries (1024 at the
//   default); busy stays high meanwhile
module bigram_markov_symbol_sampler #(
  parameter int MAX_SYMBOLS = bmss_pkg::DEF_MAX_SYMBOLS,
  parameter int WORD_LIMIT  = bmss_pkg::DEF_WORD_LIMIT,
  parameter int COUNT_WIDTH = bmss_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_func,
  input  wire logic [bmss_pkg::SYM_W-1:0] in_symbol,
  input  wire logic                       in_alphabet,
  input  wire logic                       in_word_start,
  input  wire logic                       in_word_end,
  input  wire logic [bmss_pkg::RND_W-1:0] in_random_value,
  output logic                            out_valid,
  output logic      [bmss_pkg::SYM_W-1:0] out_symbol,
  output logic                            out_end_of_word,
  output logic                            out_no_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bmss_pkg::SYM_W-1:0] cfg_num_symbols
);
  import bmss_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int RB = $clog2(MAX_SYMBOLS + 1);
  localparam int CB = $clog2(MAX_SYMBOLS + 2);
  localparam int AW = RB + CB;
  localparam int LW = $clog2(WORD_LIMIT + 1);
  localparam logic [CB-1:0] END_COL   = CB'(MAX_SYMBOLS);
  localparam logic [CB-1:0] TOT_COL   = CB'(MAX_SYMBOLS + 1);
  localparam logic [CB-1:0] FIRST_END = CB'(MAX_SYMBOLS - 1);
  localparam logic [RB-1:0] FIRST_ROW = RB'(MAX_SYMBOLS);
  localparam int RESET_NUM = (MAX_SYMBOLS < ALPHA_LIMIT) ? MAX_SYMBOLS : ALPHA_LIMIT;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TNEXT, S_TRD, S_TCHK, S_TINC,
    S_DRD, S_DCHK, S_DMOD, S_SRD, S_SCMP
  } state_t;

  state_t           state_r;
  logic [SYM_W-1:0] num_r;
  logic [RB-1:0]    tprev_r;
  logic             tvalid_r;
  logic [RB-1:0]    dprev_r;
  logic [LW-1:0]    dlen_r;
  logic             b1en_r, b2en_r;
  logic [RB-1:0]    brow_r, b2row_r;
  logic [CB-1:0]    bcol_r;
  logic [RB-1:0]    prow_r;
  logic [CB-1:0]    last_r, col_r;
  logic [CW-1:0]    r_r;
  logic [AW-1:0]    clr_r;
  logic             ov_r, oend_r, ond_r;
  logic [SYM_W-1:0] osym_r;
  logic             mod_go_r;
  logic [RND_W-1:0] rnd_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CW-1:0]    mem_wdata, mem_rdata;
  logic             mod_done;
  logic [CW-1:0]    mod_rem;
  logic             sym_ok;
  logic [SYM_W-1:0] cfg_v;

  bmss_mem #(.AW(AW), .DW(CW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  bmss_mod #(.CW(CW)) u_mod (
    .clk(clk), .rst_n(rst_n), .go(mod_go_r), .dividend(rnd_r),
    .divisor(mem_rdata), .done(mod_done), .rem(mod_rem)
  );

  assign sym_ok = in_alphabet && (in_symbol < num_r) && (int'(in_symbol) < MAX_SYMBOLS);

  always_comb begin
    cfg_v = cfg_num_symbols;
    if (cfg_v == '0) begin
      cfg_v = SYM_W'(1);
    end
    if (int'(cfg_v) > MAX_SYMBOLS) begin
      cfg_v = SYM_W'(MAX_SYMBOLS);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {brow_r, TOT_COL};
    mem_wdata = mem_rdata + 1'b1;
    mem_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_TRD: mem_raddr = {brow_r, TOT_COL};
      S_TCHK: begin
        mem_we    = (mem_rdata != '1);
        mem_raddr = {brow_r, bcol_r};
      end
      S_TINC: begin
        mem_we    = 1'b1;
        mem_waddr = {brow_r, bcol_r};
      end
      S_DRD, S_DCHK: mem_raddr = {prow_r, TOT_COL};
      S_SRD: mem_raddr = {prow_r, col_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      num_r    <= SYM_W'(RESET_NUM);
      tprev_r  <= '0;
      tvalid_r <= 1'b0;
      dprev_r  <= '0;
      dlen_r   <= '0;
      b1en_r   <= 1'b0;
      b2en_r   <= 1'b0;
      clr_r    <= '0;
      ov_r     <= 1'b0;
      mod_go_r <= 1'b0;
    end else begin
      ov_r     <= 1'b0;
      mod_go_r <= 1'b0;
      if (cfg_valid) begin
        num_r <= cfg_v;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && !in_func) begin
            state_r <= S_TNEXT;
            b1en_r  <= 1'b0;
            b2en_r  <= 1'b0;
            if (!sym_ok) begin
              tvalid_r <= 1'b0;
            end else begin
              bcol_r <= CB'(in_symbol);
              if (in_word_start) begin
                b1en_r <= 1'b1;
                brow_r <= FIRST_ROW;
              end else if (tvalid_r) begin
                b1en_r <= 1'b1;
                brow_r <= tprev_r;
              end
              b2row_r <= RB'(in_symbol);
              if (in_word_end) begin
                b2en_r   <= 1'b1;
                tvalid_r <= 1'b0;
              end else begin
                tprev_r  <= RB'(in_symbol);
                tvalid_r <= 1'b1;
              end
            end
          end else if (start) begin
            rnd_r <= in_random_value;
            if (dlen_r >= LW'(WORD_LIMIT)) begin
              dlen_r <= '0;
              ov_r   <= 1'b1;
              oend_r <= 1'b1;
              ond_r  <= 1'b0;
              osym_r <= '0;
            end else begin
              state_r <= S_DRD;
              if (dlen_r == '0) begin
                prow_r <= FIRST_ROW;
                last_r <= FIRST_END;
              end else begin
                prow_r <= dprev_r;
                last_r <= END_COL;
              end
            end
          end
        end
        S_TNEXT: begin
          if (b1en_r) begin
            b1en_r  <= 1'b0;
            state_r <= S_TRD;
          end else if (b2en_r) begin
            b2en_r  <= 1'b0;
            brow_r  <= b2row_r;
            bcol_r  <= END_COL;
            state_r <= S_TRD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_TRD: state_r <= S_TCHK;
        S_TCHK: state_r <= (mem_rdata != '1) ? S_TINC : S_TNEXT;
        S_TINC: state_r <= S_TNEXT;
        S_DRD: state_r <= S_DCHK;
        S_DCHK: begin
          if (mem_rdata == '0) begin
            dlen_r  <= '0;
            ov_r    <= 1'b1;
            oend_r  <= 1'b1;
            ond_r   <= 1'b1;
            osym_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            mod_go_r <= 1'b1;
            state_r  <= S_DMOD;
          end
        end
        S_DMOD: begin
          if (mod_done) begin
            r_r     <= mod_rem + 1'b1;
            col_r   <= '0;
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          if (r_r <= mem_rdata) begin
            ov_r    <= 1'b1;
            ond_r   <= 1'b0;
            state_r <= S_IDLE;
            if (col_r == END_COL) begin
              dlen_r <= '0;
              oend_r <= 1'b1;
              osym_r <= '0;
            end else begin
              dprev_r <= RB'(col_r);
              dlen_r  <= dlen_r + 1'b1;
              oend_r  <= 1'b0;
              osym_r  <= SYM_W'(col_r);
            end
          end else if (col_r == last_r) begin
            dlen_r  <= '0;
            ov_r    <= 1'b1;
            oend_r  <= 1'b1;
            ond_r   <= 1'b0;
            osym_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            r_r     <= r_r - mem_rdata;
            col_r   <= col_r + 1'b1;
            state_r <= S_SRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_symbol      = osym_r;
  assign out_end_of_word = oend_r;
  assign out_no_data     = ond_r;

  a_nodata_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_data |-> out_end_of_word)
    else $error("no_data without end of word");
  a_end_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_word |-> out_symbol == '0)
    else $error("end of word with nonzero symbol");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item left no trace");
  a_mod_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_DMOD)
    else $error("remainder finished outside a draw");
endmodule
`default_nettype wire
